// ----- rtl/ssms_pkg.sv -----
// Shared types, constants and the sine table for the stepper microstep sequencer.
package ssms_pkg;

	// Microsteps per half phase ramp
	localparam int MICROSTEPS = 32;
	localparam int MS_W       = (MICROSTEPS > 2) ? $clog2(MICROSTEPS) : 1;

	// Field widths
	localparam int TICK_W  = 24;
	localparam int SCALE_W = 10;
	localparam int DUTY_W  = 16;
	localparam int COUNT_W = 32;
	localparam int PIN_W   = 4;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE      = 1'd1;

	// Register reset values
	localparam logic [TICK_W-1:0]  TICKS_RESET = 24'd1000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd10;

	// Full-step coil patterns, bit3 A1, bit2 B1, bit1 A2, bit0 B2
	localparam logic [PIN_W-1:0] PAT_CW  [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
	localparam logic [PIN_W-1:0] PAT_CCW [4] = '{4'hA, 4'h9, 4'h5, 4'h6};

	typedef logic [DUTY_W-1:0] rom_t [MICROSTEPS];

	typedef struct packed {
		logic run;
		logic direction;
		logic release_req;
		logic clear_count;
	} item_t;

	typedef struct packed {
		logic [PIN_W-1:0]   coil_pins;
		logic [DUTY_W-1:0]  duty_ch2;
		logic [DUTY_W-1:0]  duty_ch3;
		logic [COUNT_W-1:0] pulse_count;
		logic               last_of_cycle;
	} result_t;

	// Pick the coil pattern for a phase in the given direction
	function automatic logic [PIN_W-1:0] coil_pattern(input logic dir, input logic [1:0] phase);
		return dir ? PAT_CCW[phase] : PAT_CW[phase];
	endfunction

	// Build the Q8.8 percent sine table with a Q2.30 Taylor series, elaborated once
	function automatic rom_t build_sine_rom();
		rom_t                r;
		logic [63:0]         x;
		logic [63:0]         term;
		logic [63:0]         v;
		logic signed [63:0]  acc;
		for (int i = 0; i < MICROSTEPS; i++) begin
			x    = ((64'(i + 1) * 64'd157) << 30) / 64'(100 * MICROSTEPS);
			term = x;
			acc  = $signed(x);
			for (int k = 1; k <= 12; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1)
					acc = acc - $signed(term);
				else
					acc = acc + $signed(term);
			end
			if (acc < 0)
				acc = '0;
			v    = ($unsigned(acc) * 64'd25600 + (64'd1 << 29)) >> 30;
			r[MS_W'(i)] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/ssms_duty.sv -----
// Sine table lookup for the rising or falling ramp and compare value scaling.
module ssms_duty import ssms_pkg::*; (
	input  logic [MS_W-1:0]    idx,
	input  logic               falling,
	input  logic [SCALE_W-1:0] duty_scale,
	output logic [DUTY_W-1:0]  duty
);

	localparam logic [MS_W-1:0] IDX_LAST = MS_W'(MICROSTEPS - 1);
	localparam logic [MS_W-1:0] REV_BASE = MS_W'(MICROSTEPS - 2);

	logic [DUTY_W-1:0]         rom_val;
	logic [DUTY_W+SCALE_W-1:0] prod;
	logic [DUTY_W+SCALE_W-9:0] scaled;

	// Rising ramp reads forward, falling ramp reads backward and ends at zero
	always_comb begin
		if (!falling)
			rom_val = SINE_ROM[idx];
		else if (idx < IDX_LAST)
			rom_val = SINE_ROM[REV_BASE - idx];
		else
			rom_val = '0;
	end

	// Scale, drop the fraction and saturate
	assign prod   = (DUTY_W+SCALE_W)'(rom_val) * (DUTY_W+SCALE_W)'(duty_scale);
	assign scaled = prod[DUTY_W+SCALE_W-1:8];
	assign duty   = (|scaled[DUTY_W+SCALE_W-9:DUTY_W]) ? {DUTY_W{1'b1}} : scaled[DUTY_W-1:0];

endmodule

// ----- rtl/ssms_core.sv -----
// Sequencer state and the per-tick step logic that forms one result.
module ssms_core import ssms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  item_t              item,
	input  logic [TICK_W-1:0]  microstep_ticks,
	input  logic [SCALE_W-1:0] duty_scale,
	output logic               emit,
	output result_t            result
);

	localparam logic [MS_W-1:0] IDX_LAST = MS_W'(MICROSTEPS - 1);

	logic               busy_q, n_busy;
	logic               dir_q, n_dir;
	logic [1:0]         phase_q, n_phase;
	logic               half_q, n_half;
	logic [MS_W-1:0]    idx_q, n_idx;
	logic [TICK_W-1:0]  tick_q, n_tick;
	logic [DUTY_W-1:0]  cmp2_q, n_cmp2;
	logic [DUTY_W-1:0]  cmp3_q, n_cmp3;
	logic [PIN_W-1:0]   pins_q, n_pins;
	logic [COUNT_W-1:0] total_q, n_total;

	logic [TICK_W-1:0]  period;
	logic [TICK_W-1:0]  tick_inc;
	logic [COUNT_W-1:0] total_base;
	logic [DUTY_W-1:0]  duty;

	assign period   = (microstep_ticks == '0) ? TICK_W'(1) : microstep_ticks;
	assign tick_inc = tick_q + TICK_W'(1);

	ssms_duty u_duty (
		.idx        (n_idx),
		.falling    (n_half),
		.duty_scale (duty_scale),
		.duty       (duty)
	);

	// Work out the next state and whether a microstep begins on this tick
	always_comb begin
		n_busy     = busy_q;
		n_dir      = dir_q;
		n_phase    = phase_q;
		n_half     = half_q;
		n_idx      = idx_q;
		n_tick     = tick_q;
		n_cmp2     = cmp2_q;
		n_cmp3     = cmp3_q;
		n_pins     = pins_q;
		total_base = item.clear_count ? '0 : total_q;
		n_total    = total_base;
		emit       = 1'b0;

		if (!busy_q) begin
			if (item.run) begin
				n_busy  = 1'b1;
				n_dir   = item.direction;
				n_phase = 2'd0;
				n_half  = 1'b0;
				n_idx   = '0;
				n_pins  = coil_pattern(item.direction, 2'd0);
				emit    = 1'b1;
			end else if (item.release_req) begin
				n_pins = '0;
			end
		end else if (tick_inc < period) begin
			n_tick = tick_inc;
		end else begin
			emit = 1'b1;
			if (idx_q == IDX_LAST) begin
				n_idx = '0;
				if (!half_q) begin
					n_half = 1'b1;
				end else begin
					n_half = 1'b0;
					if (phase_q == 2'd3) begin
						n_phase = 2'd0;
						n_busy  = 1'b0;
						n_tick  = '0;
						emit    = 1'b0;
					end else begin
						n_phase = phase_q + 2'd1;
						n_pins  = coil_pattern(dir_q, phase_q + 2'd1);
					end
				end
			end else begin
				n_idx = idx_q + MS_W'(1);
			end
		end

		// Load the channel that moves in this half phase
		if (emit) begin
			n_tick  = '0;
			n_total = total_base + COUNT_W'(1);
			if ((n_phase[0] == 1'b0) == (n_half == 1'b0))
				n_cmp3 = duty;
			else
				n_cmp2 = duty;
		end
	end

	assign result.coil_pins     = n_pins;
	assign result.duty_ch2      = n_cmp2;
	assign result.duty_ch3      = n_cmp3;
	assign result.pulse_count   = n_total;
	assign result.last_of_cycle = (n_phase == 2'd3) && n_half && (n_idx == IDX_LAST);

	// Commit the state for each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			dir_q   <= 1'b0;
			phase_q <= 2'd0;
			half_q  <= 1'b0;
			idx_q   <= '0;
			tick_q  <= '0;
			cmp2_q  <= '0;
			cmp3_q  <= '0;
			pins_q  <= '0;
			total_q <= '0;
		end else if (adv) begin
			busy_q  <= n_busy;
			dir_q   <= n_dir;
			phase_q <= n_phase;
			half_q  <= n_half;
			idx_q   <= n_idx;
			tick_q  <= n_tick;
			cmp2_q  <= n_cmp2;
			cmp3_q  <= n_cmp3;
			pins_q  <= n_pins;
			total_q <= n_total;
		end
	end

endmodule

// ----- rtl/stepper_sine_microstep_sequencer.sv -----
// Top level of the two-phase stepper sequencer with sine microstepping.
//
// Each transfer on the input channel (in_valid high, in_stall low) is one timer
// tick carrying run, direction, release_req and clear_count. A tick that begins
// a microstep produces one transfer on the output channel with the coil pins,
// both channel compare values, the running pulse count and the end-of-cycle
// flag; all other ticks produce nothing.
// Ticks pass through an input register and then the step logic into the output
// register; out_valid rises when a result that begins a microstep is loaded there.
// One tick is taken every cycle while the output side is not stalled.
// When out_valid is high and out_stall is high, the output register holds and
// the input register holds too if it is full; in_stall rises only while both are full.
// Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is the ticks per microstep, index 1 the duty scale; cfg_ready is always high.
// Write registers only while no tick is in flight.
// Reset (arst_n low) empties both registers, stops any cycle, zeroes the pins,
// compare values and pulse count, and restores the register defaults.
module stepper_sine_microstep_sequencer import ssms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 run,
	input  logic                 direction,
	input  logic                 release_req,
	input  logic                 clear_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIN_W-1:0]     coil_pins,
	output logic [DUTY_W-1:0]    duty_ch2,
	output logic [DUTY_W-1:0]    duty_ch3,
	output logic [COUNT_W-1:0]   pulse_count,
	output logic                 last_of_cycle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	logic               valid_s1;
	item_t              item_s1;
	logic               adv;
	logic               emit;
	result_t            result;
	logic               out_valid_q;
	result_t            out_q;
	logic [TICK_W-1:0]  microstep_ticks_q;
	logic [SCALE_W-1:0] duty_scale_q;

	// Pipeline moves whenever the output register is free or being taken
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			microstep_ticks_q <= TICKS_RESET;
			duty_scale_q      <= SCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MICROSTEP_TICKS: microstep_ticks_q <= cfg_data;
				CFG_DUTY_SCALE:      duty_scale_q      <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{run: run, direction: direction, release_req: release_req,
				clear_count: clear_count};
		end
	end

	ssms_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (valid_s1 && adv),
		.item            (item_s1),
		.microstep_ticks (microstep_ticks_q),
		.duty_scale      (duty_scale_q),
		.emit            (emit),
		.result          (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			out_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign coil_pins     = out_q.coil_pins;
	assign duty_ch2      = out_q.duty_ch2;
	assign duty_ch3      = out_q.duty_ch3;
	assign pulse_count   = out_q.pulse_count;
	assign last_of_cycle = out_q.last_of_cycle;

endmodule

// ----- rtl/ssms_checker.sv -----
// Port-level checks for the stepper sequencer, bound to the top level.
module ssms_checker import ssms_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [PIN_W-1:0]   coil_pins,
	input logic               last_of_cycle
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	// Stall input only while the output register is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// Drive a full-step coil pattern on every result
	a_pins_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coil_pins == 4'hA || coil_pins == 4'h6 ||
			coil_pins == 4'h5 || coil_pins == 4'h9)
		else $error("coil pins not a full-step pattern");

	// End the cycle in the last phase pattern of either direction
	a_last_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_cycle |-> coil_pins == 4'h9 || coil_pins == 4'h6)
		else $error("cycle ended outside the last phase");

endmodule

bind stepper_sine_microstep_sequencer ssms_checker u_ssms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.coil_pins     (coil_pins),
	.last_of_cycle (last_of_cycle)
);

// ----- tb/stepper_sine_microstep_sequencer_test.sv -----
// Self-checking testbench for the stepper sine microstep sequencer.
`timescale 1ns / 100ps

module stepper_sine_microstep_sequencer_test;
	import ssms_pkg::*;

	localparam int HOLD_CYCLES = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_TICKS = 260;

	// Track the sequencer state per accepted tick and queue the steps it starts
	class microstep_board;
		logic [TICK_W-1:0]  ticks_per_step;
		logic [SCALE_W-1:0] scale;
		bit                 busy;
		bit                 ccw;
		bit                 falling;
		bit [1:0]           phase;
		int unsigned        ustep;
		bit [TICK_W-1:0]    tick_cnt;
		bit [DUTY_W-1:0]    cmp2;
		bit [DUTY_W-1:0]    cmp3;
		bit [PIN_W-1:0]     pins;
		bit [COUNT_W-1:0]   total;
		bit [DUTY_W-1:0]    sine [MICROSTEPS];
		result_t            expected_steps [$];
		int unsigned        mismatches;
		int unsigned        ticks_taken;
		int unsigned        steps_checked;
		int unsigned        cycles_done;

		function new();
			longint unsigned x;
			longint unsigned term;
			longint unsigned v;
			longint          acc;
			ticks_per_step = TICKS_RESET;
			scale = SCALE_RESET;
			// Q2.30 Taylor series of the sine, rounded to Q8.8 percent
			for (int i = 0; i < MICROSTEPS; i++) begin
				x = 64'(i + 1);
				x = ((x * 64'd157) << 30) / 64'(100 * MICROSTEPS);
				term = x;
				acc = longint'(x);
				for (int k = 1; k <= 12; k++) begin
					term = (term * x) >> 30;
					term = (term * x) >> 30;
					term = term / 64'((2 * k) * (2 * k + 1));
					if (k % 2 == 1)
						acc = acc - longint'(term);
					else
						acc = acc + longint'(term);
				end
				if (acc < 0)
					acc = '0;
				v = ($unsigned(acc) * 64'd25600 + (64'd1 << 29)) >> 30;
				sine[MS_W'(i)] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
			if (idx == CFG_MICROSTEP_TICKS)
				ticks_per_step = data;
			else if (idx == CFG_DUTY_SCALE)
				scale = data[SCALE_W-1:0];
		endfunction

		function bit [PIN_W-1:0] coil_for(bit dir, bit [1:0] ph);
			case (ph)
				2'd0: return 4'hA;
				2'd1: return dir ? 4'h9 : 4'h6;
				2'd2: return 4'h5;
				default: return dir ? 4'h6 : 4'h9;
			endcase
		endfunction

		function bit [DUTY_W-1:0] scaled(bit [DUTY_W-1:0] level);
			longint unsigned v;
			v = 64'(level);
			v = (v * 64'(scale)) >> 8;
			return (v > 64'd65535) ? 16'hFFFF : v[15:0];
		endfunction

		// Begin the current microstep: load one compare and queue the step
		function void start_step();
			bit [DUTY_W-1:0] level;
			result_t         r;
			if (!falling)
				level = sine[MS_W'(ustep)];
			else
				level = (ustep < MICROSTEPS - 1) ? sine[MS_W'(MICROSTEPS - 2 - ustep)] : '0;
			if ((phase[0] == 1'b0) == !falling)
				cmp3 = scaled(level);
			else
				cmp2 = scaled(level);
			total++;
			tick_cnt = '0;
			r.coil_pins = pins;
			r.duty_ch2 = cmp2;
			r.duty_ch3 = cmp3;
			r.pulse_count = total;
			r.last_of_cycle = (phase == 2'd3 && falling && ustep == MICROSTEPS - 1);
			expected_steps.push_back(r);
		endfunction

		function void take_tick(item_t t);
			bit [TICK_W-1:0] period;
			period = (ticks_per_step == '0) ? TICK_W'(1) : ticks_per_step;
			ticks_taken++;
			if (t.clear_count)
				total = '0;
			// Idle: start a cycle or release the coils
			if (!busy) begin
				if (t.run) begin
					busy = 1'b1;
					ccw = t.direction;
					phase = 2'd0;
					falling = 1'b0;
					ustep = 0;
					pins = coil_for(ccw, phase);
					start_step();
				end else if (t.release_req) begin
					pins = '0;
				end
				return;
			end
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt < period)
				return;
			// Advance through the ramp halves and phases
			ustep++;
			if (ustep >= MICROSTEPS) begin
				ustep = 0;
				if (!falling) begin
					falling = 1'b1;
				end else begin
					falling = 1'b0;
					if (phase == 2'd3) begin
						phase = 2'd0;
						busy = 1'b0;
						tick_cnt = '0;
						return;
					end
					phase++;
					pins = coil_for(ccw, phase);
				end
			end
			start_step();
		endfunction

		function void check_field(string field, logic [COUNT_W-1:0] want,
				logic [COUNT_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_step(result_t got);
			result_t want;
			if (expected_steps.size() == 0) begin
				$error("step result with none expected: coil_pins %h pulse_count %0d",
					got.coil_pins, got.pulse_count);
				mismatches++;
				return;
			end
			want = expected_steps.pop_front();
			steps_checked++;
			if (want.last_of_cycle)
				cycles_done++;
			check_field("coil_pins", COUNT_W'(want.coil_pins), COUNT_W'(got.coil_pins));
			check_field("duty_ch2", COUNT_W'(want.duty_ch2), COUNT_W'(got.duty_ch2));
			check_field("duty_ch3", COUNT_W'(want.duty_ch3), COUNT_W'(got.duty_ch3));
			check_field("pulse_count", want.pulse_count, got.pulse_count);
			check_field("last_of_cycle", COUNT_W'(want.last_of_cycle),
				COUNT_W'(got.last_of_cycle));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 run;
	logic                 direction;
	logic                 release_req;
	logic                 clear_count;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIN_W-1:0]     coil_pins;
	logic [DUTY_W-1:0]    duty_ch2;
	logic [DUTY_W-1:0]    duty_ch3;
	logic [COUNT_W-1:0]   pulse_count;
	logic                 last_of_cycle;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	microstep_board board;
	bit             quiet;
	bit             hold_req;

	stepper_sine_microstep_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.run           (run),
		.direction     (direction),
		.release_req   (release_req),
		.clear_count   (clear_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.coil_pins     (coil_pins),
		.duty_ch2      (duty_ch2),
		.duty_ch3      (duty_ch3),
		.pulse_count   (pulse_count),
		.last_of_cycle (last_of_cycle),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop the run if it hangs
	initial begin
		#10_000_000;
		$display("stepper_sine_microstep_sequencer verification failed");
		$finish;
	end

	// Sample every transfer at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				board.take_tick(item_t'{run, direction, release_req, clear_count});
			if (out_valid && !out_stall)
				board.check_step(result_t'{coil_pins, duty_ch2, duty_ch3, pulse_count,
					last_of_cycle});
		end
	end

	// Stall the result side: random gaps, or one long hold on request
	initial begin : receiver
		int len;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
				out_stall = 1'b1;
				repeat (len) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Offer one tick and hold it until the transfer, then maybe idle a while
	task automatic send_tick(input logic r, input logic d, input logic rel, input logic clr);
		int gap;
		in_valid = 1'b1;
		run = r;
		direction = d;
		release_req = rel;
		clear_count = clr;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Wait for every expected step, then let the pipeline empty
	task automatic settle();
		in_valid = 1'b0;
		while (board.expected_steps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random stretch: mostly run requests so cycles restart at once
	task automatic run_phase(input logic [TICK_W-1:0] ticks, input logic [SCALE_W-1:0] scale_val,
			input bit calm, input bit squeeze, input int count);
		settle();
		write_reg(CFG_MICROSTEP_TICKS, ticks);
		write_reg(CFG_DUTY_SCALE, TICK_W'(scale_val));
		quiet = calm;
		for (int n = 0; n < count; n++) begin
			if (squeeze && n == count / 4)
				hold_req = 1'b1;
			if (calm && n == count / 2)
				settle();
			send_tick($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
		end
		quiet = 1'b0;
	endtask

	initial begin : stimulus
		board = new();
		quiet = 1'b1;
		hold_req = 1'b0;
		in_valid = 1'b0;
		run = 1'b0;
		direction = 1'b0;
		release_req = 1'b0;
		clear_count = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MICROSTEP_TICKS;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Idle ticks: release and clear, then a start under reset settings
		send_tick(1'b0, 1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);

		// Longest microstep: run and release while busy are ignored
		settle();
		write_reg(CFG_MICROSTEP_TICKS, {TICK_W{1'b1}});
		send_tick(1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);

		// Zero microstep length acts as one tick, full duty scale
		settle();
		write_reg(CFG_MICROSTEP_TICKS, '0);
		write_reg(CFG_DUTY_SCALE, TICK_W'(655));
		send_tick(1'b0, 1'b1, 1'b1, 1'b0);
		repeat (12)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		// Zero duty scale with every input bit set
		settle();
		write_reg(CFG_DUTY_SCALE, '0);
		repeat (4) send_tick(1'b1, 1'b1, 1'b1, 1'b1);
		quiet = 1'b0;

		run_phase(TICK_W'(1), 10'd655, 1'b0, 1'b0, PHASE_TICKS);
		run_phase(TICK_W'(2), 10'd0, 1'b0, 1'b0, PHASE_TICKS);
		run_phase(TICK_W'(1), SCALE_W'($urandom_range(0, 655)), 1'b1, 1'b0, PHASE_TICKS);
		run_phase('0, SCALE_W'($urandom_range(0, 655)), 1'b0, 1'b0, PHASE_TICKS);
		run_phase(TICK_W'($urandom_range(1, 3)), SCALE_W'($urandom_range(0, 655)), 1'b0, 1'b0,
			PHASE_TICKS);
		run_phase(TICK_W'(1), SCALE_W'($urandom_range(0, 655)), 1'b0, 1'b1, PHASE_TICKS);
		settle();

		$display("Sent %0d ticks, checked %0d microstep results over %0d full coil cycles,",
			board.ticks_taken, board.steps_checked, board.cycles_done);
		$display("with microstep lengths of 0 to 16777215 ticks and duty scales of 0 to 655.");
		if (board.mismatches == 0 && board.expected_steps.size() == 0)
			$display("stepper_sine_microstep_sequencer verification clean");
		else
			$display("stepper_sine_microstep_sequencer verification failed");
		$finish;
	end

endmodule
